FILE: design/stereo_sad_cost_volume_assert.svh
// Assertion macros shared by the stereo cost block.
`ifndef STEREO_SAD_COST_VOLUME_ASSERT_SVH
`define STEREO_SAD_COST_VOLUME_ASSERT_SVH

// An implication that must hold on every clock edge outside reset.
`define SSCV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication checked in the cycle after its antecedent.
`define SSCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sscv_pkg.sv
`default_nettype none
package sscv_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxWindow = 15;
  localparam int MaxDisp = 64;
  localparam int ColW = 10;
  localparam int SlotW = 4;
  localparam int DispW = 6;
  localparam int LineDepth = MaxWindow * MaxWidth;
  localparam int LineAw = 14;
  localparam int CsumAw = DispW + ColW;
  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegNdisp = 2'd2;
  localparam logic [1:0] RegWin = 2'd3;
endpackage
`default_nettype wire

FILE: design/stereo_sad_cost_volume.sv
// Input channel in_*: one beat per pixel pair in raster order,
//   tdata = {right_pixel, left_pixel}.
// Output channel out_*: one beat per disparity for each complete window,
//   disparities ascending, tlast on the highest one; tdata holds disparity,
//   match_cost, center_x, center_y from the lowest bit up.
// Configuration: cfg_we, cfg_addr and cfg_wdata write a register; any write
//   restarts the frame at row 0, column 0. Write only while idle.
// Each disparity of a pixel is a pass over the window rows in the line stores,
//   a write of the column sum and, once a window completes, a pass over the
//   window columns in the column-sum memory. Pixels in rows above the first
//   full window skip these passes. Each memory has a single read port.
// The column-sum memory is cleared after reset, one entry per cycle, over all
//   65536 entries, during which no pixel is accepted.
// When the receiver stalls the sequencer holds on the pending result; a new
//   pixel is accepted only once the last result of the previous one is out.
// Reset returns registers to their defaults and the raster position to zero.
`default_nettype none
module stereo_sad_cost_volume
  import sscv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // left_pixel, right_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // disparity, match_cost, center_x, center_y, pad
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ROW, S_CSUM, S_WSUM, S_OUT
  } state_t;

  state_t state_r;
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic [6:0]  ndisp_r;
  logic [3:0]  win_r;
  logic [9:0]  x_r;
  logic [11:0] y_r;
  logic [3:0]  slot_r;
  logic [5:0]  d_r;
  logic [4:0]  k_r;
  logic [4:0]  c_r;
  logic [15:0] clr_r;
  logic [11:0] colsum_r;
  logic [15:0] cost_r;
  logic [9:0]  cx_r;
  logic [11:0] cy_r;
  logic        busy_rd_r;
  logic        last_r;

  // Clamped register values.
  logic [10:0] w_c;
  logic [11:0] h_c;
  logic [6:0]  nd_c;
  logic [3:0]  ws_c;
  always_comb begin
    w_c  = (width_r == 11'd0) ? 11'd1 : (width_r > 11'd1024 ? 11'd1024 : width_r);
    h_c  = (height_r == 12'd0) ? 12'd1 : height_r;
    nd_c = (ndisp_r == 7'd0) ? 7'd1 : (ndisp_r > 7'd64 ? 7'd64 : ndisp_r);
    ws_c = (win_r == 4'd0) ? 4'd1 : win_r;
  end

  // Line stores and the column-sum memory.
  logic [7:0]  lmem [LineDepth];
  logic [7:0]  rmem [LineDepth];
  logic [11:0] cmem [1 << CsumAw];
  logic [7:0]  lrd_r, rrd_r;
  logic [11:0] crd_r;
  logic [LineAw-1:0] lwa, lra, rra;
  logic              lwe;
  logic [CsumAw-1:0] cwa, cra;
  logic [11:0]       cwd;
  logic              cwe;

  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[lwa] <= in_tdata[7:0];
      rmem[lwa] <= in_tdata[15:8];
    end
    lrd_r <= lmem[lra];
    rrd_r <= rmem[rra];
  end
  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= cwd;
    crd_r <= cmem[cra];
  end

  function automatic logic [LineAw-1:0] laddr(input logic [3:0] s, input logic [9:0] x);
    logic [LineAw+3:0] t;
    t = {10'd0, s} * 18'(MaxWidth) + 18'(x);
    return t[LineAw-1:0];
  endfunction

  // Window row and window column currently addressed.
  logic [3:0] row_slot;
  logic [4:0] srow;
  logic [9:0] x0_c;
  logic [9:0] ccol;
  always_comb begin
    srow = {1'b0, slot_r} + 5'd15 - k_r;
    if (srow >= 5'd15) srow = srow - 5'd15;
    row_slot = srow[3:0];
    x0_c = x_r + 10'd1 - 10'(ws_c);
    ccol = x0_c + 10'(c_r);
  end

  logic in_hs, out_hs, xmin;
  assign in_hs = in_tvalid && in_tready;
  assign out_hs = out_tvalid && out_tready;
  assign in_tready = (state_r == S_IDLE) && !cfg_we;
  assign xmin = (x_r >= 10'(d_r));

  // Memory address and write control.
  always_comb begin
    lwe = in_hs;
    lwa = laddr(slot_r, x_r);
    lra = laddr(row_slot, x_r);
    rra = laddr(row_slot, x_r - 10'(d_r));
    cwe = 1'b0;
    cwa = {d_r, x_r};
    cwd = colsum_r;
    cra = {d_r, ccol};
    if (state_r == S_CLEAR) begin
      cwe = 1'b1;
      cwa = clr_r;
      cwd = 12'd0;
    end else if (state_r == S_CSUM) begin
      cwe = 1'b1;
      cwd = xmin ? colsum_r : 12'd0;
    end
  end

  logic [7:0] ad;
  assign ad = (lrd_r > rrd_r) ? lrd_r - rrd_r : rrd_r - lrd_r;

  // Sequencer, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      width_r <= 11'd640;
      height_r <= 12'd480;
      ndisp_r <= 7'd64;
      win_r <= 4'd9;
      x_r <= '0;
      y_r <= '0;
      slot_r <= '0;
      clr_r <= '0;
      out_tvalid <= 1'b0;
      busy_rd_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          RegWidth:  width_r <= cfg_wdata[10:0];
          RegHeight: height_r <= cfg_wdata;
          RegNdisp:  ndisp_r <= cfg_wdata[6:0];
          RegWin:    win_r <= cfg_wdata[3:0];
          default:   width_r <= width_r;
        endcase
        x_r <= '0;
        y_r <= '0;
        slot_r <= '0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 16'd1;
          if (clr_r == 16'hFFFF) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_hs) begin
            d_r <= '0;
            k_r <= '0;
            colsum_r <= '0;
            busy_rd_r <= 1'b0;
            if ({8'd0, y_r} + 20'd1 >= 20'(ws_c)) state_r <= S_ROW;
            else state_r <= S_OUT;
          end
        end
        S_ROW: begin
          // Reads issue for row k; data of the previous row arrives now.
          busy_rd_r <= (k_r < 5'(ws_c));
          if (busy_rd_r) colsum_r <= colsum_r + 12'(ad);
          if (k_r < 5'(ws_c)) k_r <= k_r + 5'd1;
          else state_r <= S_CSUM;
        end
        S_CSUM: begin
          busy_rd_r <= 1'b0;
          c_r <= '0;
          cost_r <= '0;
          if ({1'b0, x_r} + 11'd1 >= 11'(ws_c)) state_r <= S_WSUM;
          else if (7'(d_r) + 7'd1 >= nd_c) state_r <= S_OUT;
          else begin
            d_r <= d_r + 6'd1;
            k_r <= '0;
            colsum_r <= '0;
            state_r <= S_ROW;
          end
        end
        S_WSUM: begin
          // Column c read issues now; data of column c-1 arrives.
          busy_rd_r <= (c_r < 5'(ws_c));
          if (c_r < 5'(ws_c)) begin
            if (busy_rd_r) cost_r <= cost_r + 16'(crd_r);
            c_r <= c_r + 5'd1;
          end else begin
            out_tvalid <= 1'b1;
            out_tlast <= (7'(d_r) + 7'd1 >= nd_c);
            cx_r <= x0_c + 10'(ws_c >> 1);
            cy_r <= y_r + 12'd1 - 12'(ws_c) + 12'(ws_c >> 1);
            if (x0_c < 10'(d_r)) cost_r <= 16'(ws_c) * 16'(ws_c) * 16'd255;
            else cost_r <= cost_r + 16'(crd_r);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid || out_hs) begin
            out_tvalid <= 1'b0;
            if (out_tvalid && !out_tlast) begin
              d_r <= d_r + 6'd1;
              k_r <= '0;
              colsum_r <= '0;
              state_r <= S_ROW;
            end else begin
              state_r <= S_IDLE;
              if ({1'b0, x_r} + 11'd1 >= w_c) begin
                x_r <= '0;
                if (y_r + 12'd1 >= h_c) begin
                  y_r <= '0;
                  slot_r <= '0;
                end else begin
                  y_r <= y_r + 12'd1;
                  slot_r <= (slot_r == 4'd14) ? 4'd0 : slot_r + 4'd1;
                end
              end else begin
                x_r <= x_r + 10'd1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'd0, cy_r, cx_r, cost_r, d_r};

  `include "stereo_sad_cost_volume_assert.svh"
  `SSCV_ASSERT_IMP(a_out_only_in_out, out_tvalid, state_r == S_OUT, "result outside output state")
  `SSCV_ASSERT_IMP(a_no_accept_busy, in_hs, !out_tvalid, "pixel accepted with result pending")
  `SSCV_ASSERT_NEXT(a_clear_blocks, state_r == S_CLEAR && clr_r != 16'hFFFF, !in_tready, "accept during clear")
endmodule
`default_nettype wire

FILE: bench/sad_cost_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sad_cost_checker
  import sscv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata,
  output int               fail_count,
  output int               cost_backlog
);

  typedef struct packed {
    logic [5:0]  disparity;
    logic [15:0] match_cost;
    logic [9:0]  center_x;
    logic [11:0] center_y;
    logic        last_of_run;
  } cost_beat_t;

  // Shadow copy of the block's registers and raster position.
  logic [10:0] shadow_width;
  logic [11:0] shadow_height;
  logic [6:0]  shadow_ndisp;
  logic [3:0]  shadow_win;
  int unsigned raster_col;
  int unsigned raster_row;

  logic [7:0]  left_rows  [0:MaxWindow*MaxWidth-1];
  logic [7:0]  right_rows [0:MaxWindow*MaxWidth-1];
  int unsigned col_sad    [0:MaxDisp*MaxWidth-1];

  cost_beat_t  expected_costs[$];

  initial begin
    for (int i = 0; i < MaxWindow*MaxWidth; i++) begin
      left_rows[i] = '0;
      right_rows[i] = '0;
    end
    for (int i = 0; i < MaxDisp*MaxWidth; i++) col_sad[i] = 0;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned abs_diff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Store one pixel pair and queue the costs of the window it completes.
  task automatic predict_costs(logic [7:0] lpix, logic [7:0] rpix);
    int unsigned w, h, nd, ws, x, y, slot, x0, y0, s, r, cost;
    cost_beat_t beat;
    w  = clamp_u(shadow_width, 1, MaxWidth);
    h  = clamp_u(shadow_height, 1, 4095);
    nd = clamp_u(shadow_ndisp, 1, MaxDisp);
    ws = clamp_u(shadow_win, 1, MaxWindow);
    x = raster_col;
    y = raster_row;
    if (x >= w) x = 0;
    if (y >= h) y = 0;
    slot = y % MaxWindow;
    left_rows[slot*MaxWidth + x] = lpix;
    right_rows[slot*MaxWidth + x] = rpix;
    if (y + 1 >= ws) begin
      // Column sums down the window rows for each disparity.
      for (int unsigned d = 0; d < nd; d++) begin
        s = 0;
        if (x >= d) begin
          for (int unsigned k = 0; k < ws; k++) begin
            r = (slot + MaxWindow - k) % MaxWindow;
            s += abs_diff(left_rows[r*MaxWidth + x], right_rows[r*MaxWidth + x - d]);
          end
        end
        col_sad[d*MaxWidth + x] = s;
      end
      if (x + 1 >= ws) begin
        x0 = x + 1 - ws;
        y0 = y + 1 - ws;
        for (int unsigned d = 0; d < nd; d++) begin
          if (x0 < d) begin
            cost = ws * ws * 255;
          end else begin
            cost = 0;
            for (int unsigned c = x0; c <= x; c++) cost += col_sad[d*MaxWidth + c];
          end
          beat.disparity   = d[5:0];
          beat.match_cost  = cost[15:0];
          beat.center_x    = 10'(x0 + ws / 2);
          beat.center_y    = 12'(y0 + ws / 2);
          beat.last_of_run = (d + 1 == nd);
          expected_costs.insert(expected_costs.size(), beat);
        end
      end
    end
    if (x + 1 >= w) begin
      raster_col = 0;
      raster_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      raster_col = x + 1;
      raster_row = y;
    end
  endtask

  // Track registers and pixels, and compare every result beat.
  always @(posedge clk) begin
    cost_beat_t want;
    if (!rst_n) begin
      shadow_width  <= 11'd640;
      shadow_height <= 12'd480;
      shadow_ndisp  <= 7'd64;
      shadow_win    <= 4'd9;
      raster_col = 0;
      raster_row = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          RegWidth:  shadow_width  <= cfg_wdata[10:0];
          RegHeight: shadow_height <= cfg_wdata;
          RegNdisp:  shadow_ndisp  <= cfg_wdata[6:0];
          RegWin:    shadow_win    <= cfg_wdata[3:0];
          default: ;
        endcase
        raster_col = 0;
        raster_row = 0;
      end
      if (in_tvalid && in_tready) predict_costs(in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready) begin
        if (expected_costs.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_costs.pop_front();
          if (out_tdata[5:0] !== want.disparity) begin
            $error("disparity: expected %0d, got %0d", want.disparity, out_tdata[5:0]);
            fail_count++;
          end
          if (out_tdata[21:6] !== want.match_cost) begin
            $error("match_cost: expected %0d, got %0d", want.match_cost, out_tdata[21:6]);
            fail_count++;
          end
          if (out_tdata[31:22] !== want.center_x) begin
            $error("center_x: expected %0d, got %0d", want.center_x, out_tdata[31:22]);
            fail_count++;
          end
          if (out_tdata[43:32] !== want.center_y) begin
            $error("center_y: expected %0d, got %0d", want.center_y, out_tdata[43:32]);
            fail_count++;
          end
          if (out_tlast !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_tlast);
            fail_count++;
          end
        end
      end
    end
    cost_backlog = expected_costs.size();
  end

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top
  import sscv_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // left_pixel, right_pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // disparity, match_cost, center_x, center_y, pad
  logic        out_tlast;       // last_of_run
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = RegWidth;
  logic [11:0] cfg_wdata = '0;
  int          fail_count;
  int          cost_backlog;
  bit          calm_sender;

  // Wait sized for 64 disparities of 15 rows plus loop overhead.
  localparam int PixelCycles = 1300;

  stereo_sad_cost_volume DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  sad_cost_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata, .fail_count, .cost_backlog
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    int beats_taken;
    int stall;
    bit held_long;
    bit calm;
    beats_taken = 0;
    held_long = 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && beats_taken >= 40) begin
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if ($urandom_range(0, 299) == 0) calm = !calm;
      stall = calm ? 0 : gap_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid) beats_taken++;
    end
  end

  task automatic send_pixel(logic [7:0] lpix, logic [7:0] rpix);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {rpix, lpix};
    do @(posedge clk); while (!in_tready);
    gap = calm_sender ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for the block to drain, then writes all four registers.
  task automatic program_regs(logic [11:0] width, logic [11:0] height,
                              logic [11:0] ndisp, logic [11:0] win);
    logic [11:0] vals [4];
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cost_backlog != 0) @(posedge clk);
    repeat (PixelCycles) @(posedge clk);
    vals = '{width, height, ndisp, win};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) calm_sender = !calm_sender;
      send_pixel(8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    calm_sender = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Single-pixel windows: every pixel yields a cost; intensity extremes.
    program_regs(12'd16, 12'd16, 12'd1, 12'd1);
    send_pixel(8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00);
    send_pixel(8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA);

    // Out-of-range values clamp: widest row, one-row frame, all disparities.
    program_regs(12'hFFF, 12'd0, 12'h7F, 12'd0);
    for (int i = 0; i < 5; i++) send_pixel(8'($urandom), 8'($urandom));

    // One-column image with the largest window never completes a window.
    program_regs(12'd0, 12'd4095, 12'd64, 12'd15);
    for (int i = 0; i < 4; i++) send_pixel(8'($urandom), 8'($urandom));

    // A large window over a small frame, ending on the frame wrap.
    program_regs(12'd16, 12'd12, 12'd64, 12'd12);
    send_frame(192);

    // A random small configuration.
    program_regs(12'($urandom_range(16, 24)), 12'($urandom_range(16, 20)),
                 12'($urandom_range(1, 64)), 12'($urandom_range(1, 2)));
    send_frame(24);

    in_tvalid <= 1'b0;
    while (cost_backlog != 0) @(posedge clk);
    repeat (PixelCycles) @(posedge clk);
    if (cost_backlog != 0) $error("%0d expected results never arrived", cost_backlog);
    if (fail_count == 0 && cost_backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
